// ===== rtl/prrq_pkg.sv =====
// Shared types and constants for the priority round-robin ready queue.
// Holds the command, status and controller state codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package prrq_pkg;

  // id layout: priority in the upper bits, slot in the low three bits
  localparam int SLOT_W   = 3;
  localparam int PRIO_W   = 3;
  localparam int ID_W     = PRIO_W + SLOT_W;
  localparam int TASKS    = 1 << ID_W;
  localparam int TAIL_W   = SLOT_W + 1;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  // tail code for a priority with no task
  localparam logic [TAIL_W-1:0] TAIL_EMPTY = TAIL_W'(1 << SLOT_W);

  // default number of priority levels
  localparam int PRIORITIES_DEF = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_NEXT   = 2'd2,
    CMD_SWAP   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_REJECTED = 2'd1,
    ST_NONE     = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_ADD_LINK,
    S_ADD_TAIL,
    S_RM_OWN,
    S_RM_WALK,
    S_NX_HEAD,
    S_NX_ID,
    S_SW_B,
    S_SW_W1,
    S_SW_W2,
    S_FIN
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/priority_round_robin_ready_queue.sv =====
// Ready queue for a task scheduler: per-priority circular slot lists.
// Link memory and explicit id memory are local synchronous arrays.
// Depends on prrq_pkg.
//
// Usage: one command item on the in_ channel (in_cmd, in_task_id,
// in_other_id), one result item on the out_ channel (out_status,
// out_chosen_id). Both channels use valid/stall; an item moves at a clock
// edge with valid high and stall low.
// The block handles one command at a time. A rejected command, an add to an
// empty list and a next with nothing ready finish right after the check; an
// add otherwise links, then moves the tail; a next reads the head, then its
// id; a swap reads two ids and writes both. A remove may walk up to eight
// list links, one link memory read per cycle. The next command is taken in
// the cycle after the result is loaded, even if that result still waits.
// When the receiver stalls, the finished result holds in the output
// register; a further finished result waits inside until it is taken.
// Reset (synchronous, rst_n low) empties every priority list, clears all
// present flags and makes each explicit id read as its own position; the
// block accepts items in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module priority_round_robin_ready_queue #(
  parameter int PRIORITIES = prrq_pkg::PRIORITIES_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire  [prrq_pkg::CMD_W-1:0]    in_cmd,
  input  wire  [prrq_pkg::ID_W-1:0]     in_task_id,
  input  wire  [prrq_pkg::ID_W-1:0]     in_other_id,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [prrq_pkg::STATUS_W-1:0] out_status,
  output logic [prrq_pkg::ID_W-1:0]     out_chosen_id
);

  localparam int SW = prrq_pkg::SLOT_W;
  localparam int PW = prrq_pkg::PRIO_W;
  localparam int IW = prrq_pkg::ID_W;
  localparam int TW = prrq_pkg::TAIL_W;
  localparam int NT = prrq_pkg::TASKS;
  localparam int SLOTS = 1 << SW;

  // controller and latched command
  prrq_pkg::state_t  state_r, state_nxt;
  prrq_pkg::cmd_t    cmd_r, cmd_nxt;
  logic [IW-1:0]     id1_r, id1_nxt;
  logic [IW-1:0]     id2_r, id2_nxt;
  logic [SW-1:0]     pred_r, pred_nxt;
  logic [SW-1:0]     nid_r, nid_nxt;
  logic [IW-1:0]     e1_r, e1_nxt;
  logic [PW-1:0]     sel_prio_r, sel_prio_nxt;
  prrq_pkg::status_t res_status_r, res_status_nxt;
  logic [IW-1:0]     res_chosen_r, res_chosen_nxt;

  // queue state held in flops
  logic [TW-1:0]     tail_r [PRIORITIES];
  logic [TW-1:0]     tail_nxt [PRIORITIES];
  logic [NT-1:0]     present_r, present_nxt;
  logic [NT-1:0]     ex_written_r, ex_written_nxt;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  prrq_pkg::status_t       out_status_r, out_status_nxt;
  logic [IW-1:0]           out_chosen_r, out_chosen_nxt;

  // link memory ports
  logic [SW-1:0] nx_mem [NT];
  logic          nx_we, nx_re;
  logic [IW-1:0] nx_waddr, nx_raddr;
  logic [SW-1:0] nx_wdata;
  logic [SW-1:0] nx_q_r;

  // explicit id memory ports
  logic [IW-1:0] ex_mem [NT];
  logic          ex_we, ex_re;
  logic [IW-1:0] ex_waddr, ex_raddr;
  logic [IW-1:0] ex_wdata;
  logic [IW-1:0] ex_q_r;
  logic [IW-1:0] ex_addr_q_r;
  logic          ex_wr_q_r;
  logic [IW-1:0] ex_val;

  // decoded fields and conditions
  logic [PW-1:0] prio;
  logic [SW-1:0] slot;
  logic          prio_ok;
  logic [TW-1:0] tail_cur;
  logic          add_rej, rm_rej, link_hit;
  logic          sel_any;
  logic [PW-1:0] sel_prio;
  logic          in_acc, out_free;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != prrq_pkg::S_IDLE);

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_chosen_id = out_chosen_r;

  assign prio     = id1_r[IW-1:SW];
  assign slot     = id1_r[SW-1:0];
  assign prio_ok  = (int'(prio) < PRIORITIES);
  assign tail_cur = prio_ok ? tail_r[prio] : prrq_pkg::TAIL_EMPTY;
  assign add_rej  = !prio_ok || present_r[id1_r];
  assign rm_rej   = !prio_ok || !present_r[id1_r];
  assign link_hit = (nx_q_r == slot);

  // an explicit id never written reads as its own position
  assign ex_val = ex_wr_q_r ? ex_q_r : ex_addr_q_r;

  // lowest-numbered non-empty priority
  always_comb begin
    sel_any  = 1'b0;
    sel_prio = '0;
    for (int p = PRIORITIES - 1; p >= 0; p--) begin
      if (tail_r[p] != prrq_pkg::TAIL_EMPTY) begin
        sel_any  = 1'b1;
        sel_prio = PW'(p);
      end
    end
  end

  // link memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (nx_we) begin
      nx_mem[nx_waddr] <= nx_wdata;
    end
    if (nx_re) begin
      nx_q_r <= nx_mem[nx_raddr];
    end
  end

  // explicit id memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (ex_we) begin
      ex_mem[ex_waddr] <= ex_wdata;
    end
    if (ex_re) begin
      ex_q_r      <= ex_mem[ex_raddr];
      ex_addr_q_r <= ex_raddr;
      ex_wr_q_r   <= ex_written_r[ex_raddr];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      prrq_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = prrq_pkg::S_CHECK;
        end
      end
      prrq_pkg::S_CHECK: begin
        case (cmd_r)
          prrq_pkg::CMD_ADD: begin
            if (add_rej || tail_cur == prrq_pkg::TAIL_EMPTY) begin
              state_nxt = prrq_pkg::S_FIN;
            end else begin
              state_nxt = prrq_pkg::S_ADD_LINK;
            end
          end
          prrq_pkg::CMD_REMOVE: begin
            state_nxt = rm_rej ? prrq_pkg::S_FIN : prrq_pkg::S_RM_OWN;
          end
          prrq_pkg::CMD_NEXT: begin
            state_nxt = sel_any ? prrq_pkg::S_NX_HEAD : prrq_pkg::S_FIN;
          end
          prrq_pkg::CMD_SWAP: begin
            state_nxt = prrq_pkg::S_SW_B;
          end
          default: begin
            state_nxt = prrq_pkg::S_FIN;
          end
        endcase
      end
      prrq_pkg::S_ADD_LINK: state_nxt = prrq_pkg::S_ADD_TAIL;
      prrq_pkg::S_ADD_TAIL: state_nxt = prrq_pkg::S_FIN;
      prrq_pkg::S_RM_OWN: begin
        state_nxt = link_hit ? prrq_pkg::S_FIN : prrq_pkg::S_RM_WALK;
      end
      prrq_pkg::S_RM_WALK: begin
        if (link_hit) begin
          state_nxt = prrq_pkg::S_FIN;
        end
      end
      prrq_pkg::S_NX_HEAD: state_nxt = prrq_pkg::S_NX_ID;
      prrq_pkg::S_NX_ID:   state_nxt = prrq_pkg::S_FIN;
      prrq_pkg::S_SW_B:    state_nxt = prrq_pkg::S_SW_W1;
      prrq_pkg::S_SW_W1:   state_nxt = prrq_pkg::S_SW_W2;
      prrq_pkg::S_SW_W2:   state_nxt = prrq_pkg::S_FIN;
      prrq_pkg::S_FIN: begin
        if (out_free) begin
          state_nxt = prrq_pkg::S_IDLE;
        end
      end
      default: state_nxt = prrq_pkg::S_IDLE;
    endcase
  end

  // memory controls and datapath register updates
  always_comb begin
    nx_we          = 1'b0;
    nx_waddr       = id1_r;
    nx_wdata       = slot;
    nx_re          = 1'b0;
    nx_raddr       = id1_r;
    ex_we          = 1'b0;
    ex_waddr       = id1_r;
    ex_wdata       = id1_r;
    ex_re          = 1'b0;
    ex_raddr       = id1_r;
    cmd_nxt        = cmd_r;
    id1_nxt        = id1_r;
    id2_nxt        = id2_r;
    pred_nxt       = pred_r;
    nid_nxt        = nid_r;
    e1_nxt         = e1_r;
    sel_prio_nxt   = sel_prio_r;
    res_status_nxt = res_status_r;
    res_chosen_nxt = res_chosen_r;
    tail_nxt       = tail_r;
    present_nxt    = present_r;
    ex_written_nxt = ex_written_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_chosen_nxt = out_chosen_r;
    case (state_r)
      // latch the command item
      prrq_pkg::S_IDLE: begin
        if (in_acc) begin
          cmd_nxt = prrq_pkg::cmd_t'(in_cmd);
          id1_nxt = in_task_id;
          id2_nxt = in_other_id;
        end
      end
      // check, and start the first memory access where there is one
      prrq_pkg::S_CHECK: begin
        res_chosen_nxt = '0;
        res_status_nxt = prrq_pkg::ST_DONE;
        case (cmd_r)
          prrq_pkg::CMD_ADD: begin
            if (add_rej) begin
              res_status_nxt = prrq_pkg::ST_REJECTED;
            end else if (tail_cur == prrq_pkg::TAIL_EMPTY) begin
              nx_we                 = 1'b1;
              ex_we                 = 1'b1;
              ex_written_nxt[id1_r] = 1'b1;
              present_nxt[id1_r]    = 1'b1;
              tail_nxt[prio]        = {1'b0, slot};
            end else begin
              nx_re    = 1'b1;
              nx_raddr = {prio, tail_cur[SW-1:0]};
            end
          end
          prrq_pkg::CMD_REMOVE: begin
            if (rm_rej) begin
              res_status_nxt = prrq_pkg::ST_REJECTED;
            end else begin
              nx_re = 1'b1;
            end
          end
          prrq_pkg::CMD_NEXT: begin
            if (!sel_any) begin
              res_status_nxt = prrq_pkg::ST_NONE;
            end else begin
              sel_prio_nxt = sel_prio;
              nx_re        = 1'b1;
              nx_raddr     = {sel_prio, tail_r[sel_prio][SW-1:0]};
            end
          end
          prrq_pkg::CMD_SWAP: begin
            ex_re = 1'b1;
          end
          default: begin
            res_status_nxt = prrq_pkg::ST_DONE;
          end
        endcase
      end
      // new task takes over the old tail's link
      prrq_pkg::S_ADD_LINK: begin
        nx_we    = 1'b1;
        nx_wdata = nx_q_r;
      end
      // old tail now points at the new task
      prrq_pkg::S_ADD_TAIL: begin
        nx_we                 = 1'b1;
        nx_waddr              = {prio, tail_cur[SW-1:0]};
        nx_wdata              = slot;
        ex_we                 = 1'b1;
        ex_written_nxt[id1_r] = 1'b1;
        present_nxt[id1_r]    = 1'b1;
        tail_nxt[prio]        = {1'b0, slot};
      end
      // own link known: single task empties the list, else walk from tail
      prrq_pkg::S_RM_OWN: begin
        nid_nxt = nx_q_r;
        if (link_hit) begin
          tail_nxt[prio]     = prrq_pkg::TAIL_EMPTY;
          present_nxt[id1_r] = 1'b0;
        end else begin
          pred_nxt = tail_cur[SW-1:0];
          nx_re    = 1'b1;
          nx_raddr = {prio, tail_cur[SW-1:0]};
        end
      end
      // follow links until the predecessor is found, then unlink
      prrq_pkg::S_RM_WALK: begin
        if (link_hit) begin
          nx_we              = 1'b1;
          nx_waddr           = {prio, pred_r};
          nx_wdata           = nid_r;
          present_nxt[id1_r] = 1'b0;
          if (slot == tail_cur[SW-1:0]) begin
            tail_nxt[prio] = {1'b0, pred_r};
          end
        end else begin
          pred_nxt = nx_q_r;
          nx_re    = 1'b1;
          nx_raddr = {prio, nx_q_r};
        end
      end
      // head becomes the tail, fetch its explicit id
      prrq_pkg::S_NX_HEAD: begin
        tail_nxt[sel_prio_r] = {1'b0, nx_q_r};
        ex_re                = 1'b1;
        ex_raddr             = {sel_prio_r, nx_q_r};
      end
      prrq_pkg::S_NX_ID: begin
        res_chosen_nxt = ex_val;
      end
      // keep the first id, fetch the second
      prrq_pkg::S_SW_B: begin
        e1_nxt   = ex_val;
        ex_re    = 1'b1;
        ex_raddr = id2_r;
      end
      prrq_pkg::S_SW_W1: begin
        ex_we                 = 1'b1;
        ex_wdata              = ex_val;
        ex_written_nxt[id1_r] = 1'b1;
      end
      prrq_pkg::S_SW_W2: begin
        ex_we                 = 1'b1;
        ex_waddr              = id2_r;
        ex_wdata              = e1_r;
        ex_written_nxt[id2_r] = 1'b1;
      end
      // hand the result to the output register
      prrq_pkg::S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_chosen_nxt = res_chosen_r;
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && out_stall;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= prrq_pkg::S_IDLE;
      out_valid_r  <= 1'b0;
      present_r    <= '0;
      ex_written_r <= '0;
      for (int p = 0; p < PRIORITIES; p++) begin
        tail_r[p] <= prrq_pkg::TAIL_EMPTY;
      end
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      present_r    <= present_nxt;
      ex_written_r <= ex_written_nxt;
      tail_r       <= tail_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    id1_r        <= id1_nxt;
    id2_r        <= id2_nxt;
    pred_r       <= pred_nxt;
    nid_r        <= nid_nxt;
    e1_r         <= e1_nxt;
    sel_prio_r   <= sel_prio_nxt;
    res_status_r <= res_status_nxt;
    res_chosen_r <= res_chosen_nxt;
    out_status_r <= out_status_nxt;
    out_chosen_r <= out_chosen_nxt;
  end

  // a new result appears only when the controller finishes an item
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == prrq_pkg::S_FIN)
    else $error("result loaded outside the finish step");

  // only a successful next returns a non-zero id
  a_chosen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != prrq_pkg::ST_DONE |-> out_chosen_r == '0)
    else $error("chosen id set on a failed command");

  // link memory is never read and written in the same cycle
  a_nx_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(nx_we && nx_re))
    else $error("link memory read and write overlap");

  // the walk only runs for a task still in its list
  a_walk_present: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == prrq_pkg::S_RM_WALK |-> present_r[id1_r])
    else $error("remove walk on an absent task");

  // an empty tail matches a priority with no present task
  for (genvar gp = 0; gp < PRIORITIES; gp++) begin : g_tail_chk
    a_tail_empty: assert property (@(posedge clk) disable iff (!rst_n)
      (tail_r[gp] == prrq_pkg::TAIL_EMPTY) == (present_r[gp*SLOTS +: SLOTS] == '0))
      else $error("tail pointer disagrees with present flags");
  end

endmodule

`default_nettype wire

// ===== dv/tb_priority_round_robin_ready_queue.sv =====
// Testbench for the priority round-robin ready queue: directed and random
// command streams checked against a built-in model of the per-priority lists.
// Depends on prrq_pkg and priority_round_robin_ready_queue.
`timescale 1ns / 1ps

module tb_priority_round_robin_ready_queue;

  localparam int PRIO_LEVELS = prrq_pkg::PRIORITIES_DEF;
  localparam int HOLD_CYCLES = 150;
  localparam int SETTLE_CYCLES = 30;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    prrq_pkg::status_t         status;
    logic [prrq_pkg::ID_W-1:0] chosen;
  } reply_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [prrq_pkg::CMD_W-1:0]    in_cmd = '0;
  logic [prrq_pkg::ID_W-1:0]     in_task_id = '0;
  logic [prrq_pkg::ID_W-1:0]     in_other_id = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [prrq_pkg::STATUS_W-1:0] out_status;
  logic [prrq_pkg::ID_W-1:0]     out_chosen_id;

  // model of the ready lists
  logic [prrq_pkg::SLOT_W-1:0] link_mem [prrq_pkg::TASKS];
  logic [prrq_pkg::TAIL_W-1:0] tail_of [1 << prrq_pkg::PRIO_W];
  bit                          in_list [prrq_pkg::TASKS];
  logic [prrq_pkg::ID_W-1:0]   xid [prrq_pkg::TASKS];

  reply_t awaited_replies[$];
  int     fail_count = 0;
  bit     tx_idle_on = 1'b0;
  bit     rx_idle_on = 1'b0;
  bit     hold_on = 1'b0;
  event   hold_start;

  priority_round_robin_ready_queue #(
    .PRIORITIES(PRIO_LEVELS)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_task_id   (in_task_id),
    .in_other_id  (in_other_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_chosen_id(out_chosen_id)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // state right after reset
  function automatic void clear_lists();
    for (int i = 0; i < prrq_pkg::TASKS; i++) begin
      link_mem[i] = '0;
      in_list[i]  = 1'b0;
      xid[i]      = prrq_pkg::ID_W'(i);
    end
    for (int p = 0; p < (1 << prrq_pkg::PRIO_W); p++) begin
      tail_of[p] = prrq_pkg::TAIL_EMPTY;
    end
  endfunction

  // apply one command to the model and return the reply it gives
  function automatic reply_t schedule_command(prrq_pkg::cmd_t cmd,
                                              logic [prrq_pkg::ID_W-1:0] id_a,
                                              logic [prrq_pkg::ID_W-1:0] id_b);
    reply_t                      r;
    logic [prrq_pkg::PRIO_W-1:0] prio;
    logic [prrq_pkg::SLOT_W-1:0] slot;
    logic [prrq_pkg::SLOT_W-1:0] pred;
    logic [prrq_pkg::SLOT_W-1:0] head;
    logic [prrq_pkg::TAIL_W-1:0] tail;
    logic [prrq_pkg::ID_W-1:0]   tmp;
    logic [prrq_pkg::PRIO_W-1:0] pp;
    int                          k;
    r.status = prrq_pkg::ST_DONE;
    r.chosen = '0;
    prio = id_a[prrq_pkg::ID_W-1:prrq_pkg::SLOT_W];
    slot = id_a[prrq_pkg::SLOT_W-1:0];
    tail = tail_of[prio];
    case (cmd)
      prrq_pkg::CMD_ADD: begin
        if (prio >= PRIO_LEVELS || in_list[id_a]) begin
          r.status = prrq_pkg::ST_REJECTED;
        end else begin
          // splice in after the tail; the new task becomes the tail
          if (tail == prrq_pkg::TAIL_EMPTY) begin
            link_mem[id_a] = slot;
          end else begin
            link_mem[id_a] = link_mem[{prio, tail[prrq_pkg::SLOT_W-1:0]}];
            link_mem[{prio, tail[prrq_pkg::SLOT_W-1:0]}] = slot;
          end
          xid[id_a]     = id_a;
          in_list[id_a] = 1'b1;
          tail_of[prio] = {1'b0, slot};
        end
      end
      prrq_pkg::CMD_REMOVE: begin
        if (prio >= PRIO_LEVELS || !in_list[id_a]) begin
          r.status = prrq_pkg::ST_REJECTED;
        end else begin
          if (link_mem[id_a] == slot) begin
            tail_of[prio] = prrq_pkg::TAIL_EMPTY;
          end else begin
            // find the predecessor, starting at the tail
            pred = tail[prrq_pkg::SLOT_W-1:0];
            for (k = 0; k < 8 && link_mem[{prio, pred}] != slot; k++) begin
              pred = link_mem[{prio, pred}];
            end
            link_mem[{prio, pred}] = link_mem[id_a];
            if ({1'b0, slot} == tail) begin
              tail_of[prio] = {1'b0, pred};
            end
          end
          in_list[id_a] = 1'b0;
        end
      end
      prrq_pkg::CMD_NEXT: begin
        r.status = prrq_pkg::ST_NONE;
        for (k = 0; k < PRIO_LEVELS && r.status == prrq_pkg::ST_NONE; k++) begin
          pp = prrq_pkg::PRIO_W'(k);
          if (tail_of[pp] != prrq_pkg::TAIL_EMPTY) begin
            head        = link_mem[{pp, tail_of[pp][prrq_pkg::SLOT_W-1:0]}];
            tail_of[pp] = {1'b0, head};
            r.chosen    = xid[{pp, head}];
            r.status    = prrq_pkg::ST_DONE;
          end
        end
      end
      default: begin
        tmp        = xid[id_a];
        xid[id_a]  = xid[id_b];
        xid[id_b]  = tmp;
      end
    endcase
    return r;
  endfunction

  // offer one item, wait for it to be taken, then record its reply
  task automatic issue_command(prrq_pkg::cmd_t cmd, logic [prrq_pkg::ID_W-1:0] id_a,
                               logic [prrq_pkg::ID_W-1:0] id_b);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_task_id  <= id_a;
    in_other_id <= id_b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    awaited_replies.push_back(schedule_command(cmd, id_a, id_b));
  endtask

  // stop offering and wait for every outstanding reply
  task automatic wait_replies_drained();
    in_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
  endtask

  // random command stream; prio_span limits the priority of the first id, noise commands apart
  task automatic run_random_commands(int count, int prio_span);
    int                        roll;
    prrq_pkg::cmd_t            cmd;
    logic [prrq_pkg::ID_W-1:0] id_a;
    logic [prrq_pkg::ID_W-1:0] id_b;
    logic [prrq_pkg::ID_W-1:0] live[$];
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      id_a = prrq_pkg::ID_W'($urandom);
      id_b = prrq_pkg::ID_W'($urandom);
      if (roll < 10) begin
        // noise: any command on any ids
        cmd = prrq_pkg::cmd_t'($urandom_range(0, 3));
      end else begin
        id_a[prrq_pkg::ID_W-1:prrq_pkg::SLOT_W] =
          prrq_pkg::PRIO_W'($urandom_range(0, prio_span - 1));
        if (roll < 40) begin
          cmd = prrq_pkg::CMD_ADD;
        end else if (roll < 65) begin
          cmd = prrq_pkg::CMD_REMOVE;
          live.delete();
          for (int i = 0; i < prrq_pkg::TASKS; i++) begin
            if (in_list[i]) live.push_back(prrq_pkg::ID_W'(i));
          end
          if (live.size() > 0 && $urandom_range(0, 4) != 0) begin
            id_a = live[$urandom_range(0, live.size() - 1)];
          end
        end else if (roll < 88) begin
          cmd = prrq_pkg::CMD_NEXT;
        end else begin
          cmd = prrq_pkg::CMD_SWAP;
        end
      end
      issue_command(cmd, id_a, id_b);
    end
  endtask

  // extremes and each special case of the list handling
  task automatic test_directed();
    tx_idle_on = 1'b0;
    rx_idle_on <= 1'b0;
    issue_command(prrq_pkg::CMD_NEXT, 6'd0, 6'd0);      // empty scheduler
    issue_command(prrq_pkg::CMD_SWAP, 6'd0, 6'd63);
    issue_command(prrq_pkg::CMD_SWAP, 6'd63, 6'd0);
    issue_command(prrq_pkg::CMD_SWAP, 6'd9, 6'd9);      // swap with itself
    issue_command(prrq_pkg::CMD_REMOVE, 6'd5, 6'd0);    // absent remove
    issue_command(prrq_pkg::CMD_ADD, 6'd0, 6'd0);
    issue_command(prrq_pkg::CMD_ADD, 6'd0, 6'd0);       // duplicate add
    issue_command(prrq_pkg::CMD_ADD, 6'd63, 6'd0);
    issue_command(prrq_pkg::CMD_ADD, 6'd1, 6'd0);
    issue_command(prrq_pkg::CMD_ADD, 6'd2, 6'd0);
    issue_command(prrq_pkg::CMD_ADD, 6'd3, 6'd0);
    issue_command(prrq_pkg::CMD_SWAP, 6'd2, 6'd63);     // explicit ids now differ
    issue_command(prrq_pkg::CMD_NEXT, 6'd0, 6'd0);
    issue_command(prrq_pkg::CMD_NEXT, 6'd0, 6'd0);
    issue_command(prrq_pkg::CMD_NEXT, 6'd0, 6'd0);
    issue_command(prrq_pkg::CMD_REMOVE, 6'd3, 6'd0);    // not the tail
    issue_command(prrq_pkg::CMD_REMOVE, 6'd2, 6'd0);    // the tail
    issue_command(prrq_pkg::CMD_NEXT, 6'd0, 6'd0);
    issue_command(prrq_pkg::CMD_REMOVE, 6'd0, 6'd0);
    issue_command(prrq_pkg::CMD_REMOVE, 6'd1, 6'd0);    // empties priority 0
    issue_command(prrq_pkg::CMD_NEXT, 6'd63, 6'd63);    // falls through to priority 7
    issue_command(prrq_pkg::CMD_REMOVE, 6'd63, 6'd0);   // only task of its list
    issue_command(prrq_pkg::CMD_REMOVE, 6'd63, 6'd0);
    issue_command(prrq_pkg::CMD_NEXT, 6'd0, 6'd0);
    wait_replies_drained();
  endtask

  // random mix under each combination of idling on both sides
  task automatic test_random_mix();
    for (int phase = 0; phase < 4; phase++) begin
      tx_idle_on = phase[0];
      rx_idle_on <= phase[1];
      run_random_commands(160, 8);
      wait_replies_drained();
    end
  endtask

  // few priorities so lists fill up and removes walk far
  task automatic test_full_lists();
    tx_idle_on = 1'b1;
    rx_idle_on <= 1'b1;
    run_random_commands(150, 2);
    wait_replies_drained();
  endtask

  // receiver holds off while commands keep coming
  task automatic test_output_hold();
    tx_idle_on = 1'b0;
    rx_idle_on <= 1'b0;
    -> hold_start;
    run_random_commands(20, 8);
    wait_replies_drained();
  endtask

  // sender pauses until every reply is back, then resumes
  task automatic test_sender_pause();
    tx_idle_on = 1'b1;
    rx_idle_on <= 1'b1;
    run_random_commands(20, 4);
    wait_replies_drained();
    run_random_commands(20, 4);
    wait_replies_drained();
  endtask

  // long receiver hold, counted here
  initial begin
    forever begin
      @(hold_start);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_on <= 1'b0;
    end
  end

  // receiver: take replies, compare with the oldest awaited one
  initial begin
    int     stall_left;
    reply_t want;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (awaited_replies.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("unexpected reply: status %0d chosen %0d", out_status, out_chosen_id);
          end
        end else begin
          want = awaited_replies.pop_front();
          if (out_status !== want.status || out_chosen_id !== want.chosen) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("reply mismatch: status exp %0d got %0d, chosen exp %0d got %0d",
                       want.status, out_status, want.chosen, out_chosen_id);
            end
          end
        end
        stall_left = rx_idle_on ? $urandom_range(0, 6) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= hold_on || (stall_left > 0);
    end
  end

  initial begin
    clear_lists();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_mix();
    test_full_lists();
    test_output_hold();
    test_sender_pause();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && awaited_replies.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
